// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert an implication at every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error(msg);
// Assert an implication whose consequent is checked in the next cycle.
`define CHK_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error(msg);
`endif

// ===== rtl/cml_pkg.sv =====
// ----------------------------------------------------------------------------
// cml_pkg
// Types and constants of the multichannel convolution layer.
// ----------------------------------------------------------------------------
package cml_pkg;
  localparam int DEF_IN_SIZE      = 14;
  localparam int DEF_IN_CHANNELS  = 6;
  localparam int DEF_OUT_CHANNELS = 16;
  localparam int DEF_KERNEL_SIZE  = 5;
  localparam int RES_LIMIT        = 16;
  localparam int ACC_W            = 40;

  typedef enum logic [1:0] {
    OP_LOAD_W = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_LOAD_F = 2'd2,
    OP_COMPUTE = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [11:0]        address;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [11:0]        out_position;
    logic [3:0]         out_channel;
    logic signed [15:0] out_value;
    logic               last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_MAC,
    ST_DRAIN,
    ST_BIAS,
    ST_EMIT
  } state_t;

  // Control from sequencer to datapath.
  typedef struct packed {
    logic clear;
    logic mac_en;
    logic bias_en;
  } mac_ctrl_t;
endpackage

// ===== rtl/cml_mac.sv =====
// ----------------------------------------------------------------------------
// cml_mac
// Shared multiply-accumulate with a registered product, bias add and
// Q8.8 truncate and saturate.
// ----------------------------------------------------------------------------
module cml_mac import cml_pkg::*; (
  input  logic               clk,
  input  mac_ctrl_t          ctrl,
  input  logic signed [15:0] feat,
  input  logic signed [15:0] wgt,
  input  logic signed [15:0] bias,
  output logic signed [15:0] result
);
  logic signed [31:0]      prod_r;
  logic                    prod_v_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W-9:0] q;

  always_ff @(posedge clk) begin
    prod_r   <= feat * wgt;
    prod_v_r <= ctrl.mac_en;
    acc_r    <= acc_nxt;
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (prod_v_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end else if (ctrl.bias_en) begin
      acc_nxt = acc_r + {{(ACC_W-24){bias[15]}}, bias, 8'd0};
    end
  end

  assign q = acc_r[ACC_W-1:8];
  always_comb begin
    if (q > 32'sd32767) result = 16'sh7fff;
    else if (q < -32'sd32768) result = -16'sh8000;
    else result = q[15:0];
  end
endmodule

// ===== rtl/conv_multichannel_5x5_layer.sv =====
// ----------------------------------------------------------------------------
// conv_multichannel_5x5_layer
// Valid stride-1 multichannel convolution with bias, Q8.8 in and out.
// ----------------------------------------------------------------------------
// Usage: drive in_item and raise start while busy is low; the transaction is
// taken at that edge. Loads (weight, bias, feature) write one word into the
// weight, bias or feature memory and leave busy low; out-of-range addresses
// are dropped. A compute transaction names output position row*OW+col and
// produces one result per output channel (at most 16), each shown for one
// cycle with out_valid; out_item.last marks the final one. Positions out of
// range produce nothing. The position is first split into row and column by
// repeated subtraction. Each channel then passes through setup, then
// IN_CHANNELS*K*K products through the single MAC (fed by one read port per
// memory), then pipeline drain, bias and output. Reset returns the sequencer
// to idle; the memories are not cleared and must be loaded before use. The
// receiver cannot stall: results are presented exactly once.
// ----------------------------------------------------------------------------
module conv_multichannel_5x5_layer import cml_pkg::*; #(
  parameter int IN_SIZE      = DEF_IN_SIZE,
  parameter int IN_CHANNELS  = DEF_IN_CHANNELS,
  parameter int OUT_CHANNELS = DEF_OUT_CHANNELS,
  parameter int KERNEL_SIZE  = DEF_KERNEL_SIZE
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);
  localparam int OW     = (KERNEL_SIZE <= IN_SIZE) ? IN_SIZE - KERNEL_SIZE + 1 : 0;
  localparam int W_DEPTH = OUT_CHANNELS * IN_CHANNELS * KERNEL_SIZE * KERNEL_SIZE;
  localparam int F_DEPTH = IN_SIZE * IN_SIZE * IN_CHANNELS;
  localparam int NRES   = (OUT_CHANNELS < RES_LIMIT) ? OUT_CHANNELS : RES_LIMIT;
  localparam int WA_W   = $clog2(W_DEPTH);
  localparam int FA_W   = $clog2(F_DEPTH);
  localparam int BA_W   = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
  localparam int C_W    = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
  localparam int K_W    = (KERNEL_SIZE > 1) ? $clog2(KERNEL_SIZE) : 1;
  localparam int P_W    = 7;

  logic signed [15:0] wmem [W_DEPTH];
  logic signed [15:0] fmem [F_DEPTH];
  logic signed [15:0] bmem [OUT_CHANNELS];
  logic signed [15:0] wrd_r, frd_r, brd_r;

  state_t     state_r, state_nxt;
  logic [11:0] pos_r;
  logic [P_W-1:0] row_r;
  logic [11:0] col_r;
  logic [3:0]  ch_r;
  logic [C_W-1:0] c_r;
  logic [K_W-1:0] x_r, y_r;
  logic [WA_W-1:0] wa_r;
  logic [FA_W-1:0] fa_r;
  logic [1:0]  cnt_r;
  mac_ctrl_t   ctrl;
  logic signed [15:0] res;
  logic        accept;
  logic        rd_en;
  logic        mac_v_r;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (accept && in_item.operation == OP_LOAD_W && 32'(in_item.address) < W_DEPTH)
      wmem[in_item.address[WA_W-1:0]] <= in_item.value;
    if (accept && in_item.operation == OP_LOAD_F && 32'(in_item.address) < F_DEPTH)
      fmem[in_item.address[FA_W-1:0]] <= in_item.value;
    if (accept && in_item.operation == OP_LOAD_B && 32'(in_item.address) < OUT_CHANNELS)
      bmem[in_item.address[BA_W-1:0]] <= in_item.value;
    if (rd_en) begin
      wrd_r <= wmem[wa_r];
      frd_r <= fmem[fa_r];
    end
    brd_r <= bmem[BA_W'(ch_r)];
  end

  assign rd_en = (state_r == ST_MAC);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    ctrl         = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_item.operation == OP_COMPUTE && OW > 0 &&
            32'(in_item.address) < OW * OW)
          state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (32'(col_r) < OW) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        ctrl.clear = 1'b1;
        state_nxt  = ST_MAC;
      end
      ST_MAC: begin
        if (32'(c_r) == IN_CHANNELS-1 && 32'(x_r) == KERNEL_SIZE-1 &&
            32'(y_r) == KERNEL_SIZE-1)
          state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (cnt_r == 2'd1) state_nxt = ST_BIAS;
      end
      ST_BIAS: begin
        ctrl.bias_en = 1'b1;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        state_nxt = (32'(ch_r) == NRES-1) ? ST_IDLE : ST_SETUP;
      end
      default: state_nxt = ST_IDLE;
    endcase
    ctrl.mac_en = mac_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) mac_v_r <= 1'b0;
    else mac_v_r <= rd_en;
  end

  // address generation
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && accept) begin
      pos_r <= in_item.address;
      row_r <= '0;
      col_r <= in_item.address;
      ch_r  <= '0;
    end
    cnt_r <= (state_r == ST_DRAIN) ? cnt_r + 2'd1 : 2'd0;
    if (state_r == ST_DIV) begin
      if (32'(col_r) >= OW) begin
        row_r <= row_r + 1'b1;
        col_r <= col_r - 12'(OW);
      end
    end else if (state_r == ST_SETUP) begin
      c_r  <= '0;
      x_r  <= '0;
      y_r  <= '0;
      wa_r <= WA_W'(32'(ch_r) * IN_CHANNELS * KERNEL_SIZE * KERNEL_SIZE);
      fa_r <= FA_W'((32'(row_r) * IN_SIZE + 32'(col_r)) * IN_CHANNELS);
    end else if (state_r == ST_MAC) begin
      if (32'(y_r) != KERNEL_SIZE-1) begin
        y_r  <= y_r + 1'b1;
        wa_r <= wa_r + 1'b1;
        fa_r <= fa_r + FA_W'(IN_CHANNELS);
      end else if (32'(x_r) != KERNEL_SIZE-1) begin
        y_r  <= '0;
        x_r  <= x_r + 1'b1;
        wa_r <= wa_r + 1'b1;
        fa_r <= fa_r + FA_W'(IN_CHANNELS * (IN_SIZE - KERNEL_SIZE + 1));
      end else begin
        y_r  <= '0;
        x_r  <= '0;
        c_r  <= c_r + 1'b1;
        wa_r <= wa_r + 1'b1;
        fa_r <= FA_W'((32'(row_r) * IN_SIZE + 32'(col_r)) * IN_CHANNELS + 32'(c_r) + 1);
      end
    end else if (state_r == ST_EMIT) begin
      ch_r <= ch_r + 4'd1;
    end
  end

  cml_mac u_mac (
    .clk    (clk),
    .ctrl   (ctrl),
    .feat   (frd_r),
    .wgt    (wrd_r),
    .bias   (brd_r),
    .result (res)
  );

  assign out_valid             = (state_r == ST_EMIT);
  assign out_item.out_position = pos_r;
  assign out_item.out_channel  = ch_r;
  assign out_item.out_value    = res;
  assign out_item.last         = (32'(ch_r) == NRES-1);
endmodule

// ===== rtl/cml_checker.sv =====
// ----------------------------------------------------------------------------
// cml_checker
// Port-level checks of the convolution layer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module cml_checker import cml_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);
  `CHK_IMPL(a_out_busy, clk, rst_n, out_valid, busy, "result outside a run")
  `CHK_NEXT(a_last_ends, clk, rst_n, out_valid && out_item.last, !busy, "busy after last")
  `CHK_NEXT(a_gap, clk, rst_n, out_valid && !out_item.last, !out_valid, "back to back results")
  `CHK_NEXT(a_chan, clk, rst_n, out_valid && !out_item.last,
    $stable(out_item.out_position), "position changed in run")
endmodule

bind conv_multichannel_5x5_layer cml_checker u_cml_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);

// ===== test/tb_conv_multichannel_5x5_layer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_conv_multichannel_5x5_layer
// Fills the weight, bias and feature memories, then issues loads and compute
// transactions. Extreme values drive saturation at both ends. Out-of-range
// loads and positions are included. A mixed random phase follows. Each
// accepted transaction goes to a convolution predictor, and every strobed
// result is checked field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module tb_conv_multichannel_5x5_layer;
  import cml_pkg::*;

  localparam int ISZ     = DEF_IN_SIZE;
  localparam int ICH     = DEF_IN_CHANNELS;
  localparam int OCH     = DEF_OUT_CHANNELS;
  localparam int KSZ     = DEF_KERNEL_SIZE;
  localparam int OW      = (KSZ <= ISZ) ? ISZ - KSZ + 1 : 0;
  localparam int NPOS    = OW * OW;
  localparam int W_DEPTH = OCH * ICH * KSZ * KSZ;
  localparam int B_DEPTH = OCH;
  localparam int F_DEPTH = ISZ * ISZ * ICH;
  localparam int NRES    = (OCH < RES_LIMIT) ? OCH : RES_LIMIT;
  localparam int CYCLE_LIMIT = 4000000;

  class conv_predictor;
    logic signed [15:0] weights [W_DEPTH];
    logic signed [15:0] biases [B_DEPTH];
    logic signed [15:0] features [F_DEPTH];
    out_item_t expected_results[$];
    int errors;

    function void note_transaction(in_item_t t);
      int row;
      int col;
      logic signed [39:0] acc;
      logic signed [31:0] prod;
      logic signed [31:0] q;
      out_item_t r;
      case (op_t'(t.operation))
        OP_LOAD_W: if (t.address < W_DEPTH) weights[t.address] = t.value;
        OP_LOAD_B: if (t.address < B_DEPTH) biases[t.address] = t.value;
        OP_LOAD_F: if (t.address < F_DEPTH) features[t.address] = t.value;
        OP_COMPUTE: begin
          if (t.address < NPOS) begin
            row = t.address / OW;
            col = t.address % OW;
            for (int k = 0; k < NRES; k++) begin
              acc = '0;
              for (int c = 0; c < ICH; c++)
                for (int x = 0; x < KSZ; x++)
                  for (int y = 0; y < KSZ; y++) begin
                    prod = features[((row + x) * ISZ + col + y) * ICH + c]
                         * weights[((k * ICH + c) * KSZ + x) * KSZ + y];
                    acc = acc + {{8{prod[31]}}, prod};
                  end
              acc = acc + {{16{biases[k][15]}}, biases[k], 8'h00};
              q = acc[39:8];
              r.out_position = t.address;
              r.out_channel  = k[3:0];
              if (q > 32767) r.out_value = 16'sh7fff;
              else if (q < -32768) r.out_value = 16'sh8000;
              else r.out_value = q[15:0];
              r.last = (k == NRES - 1);
              expected_results.push_back(r);
            end
          end
        end
      endcase
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    task check_result(out_item_t r);
      out_item_t e;
      if (expected_results.size() == 0) begin
        report("unexpected result, position", r.out_position, 0);
      end else begin
        e = expected_results.pop_front();
        if (r.out_position !== e.out_position) report("position", r.out_position, e.out_position);
        if (r.out_channel !== e.out_channel) report("channel", r.out_channel, e.out_channel);
        if (r.out_value !== e.out_value) report("value", r.out_value, e.out_value);
        if (r.last !== e.last) report("last", r.last, e.last);
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_item;
  logic out_valid;
  out_item_t out_item;
  conv_predictor conv_model;
  int cycles;
  bit allow_gaps;

  conv_multichannel_5x5_layer DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[conv_multichannel_5x5_layer] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) conv_model.check_result(out_item);
  end

  task pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task send(op_t op, int addr, int val);
    if (allow_gaps && $urandom_range(0, 3) == 0) pause($urandom_range(1, 13));
    in_item.operation <= op;
    in_item.address   <= addr[11:0];
    in_item.value     <= val[15:0];
    start <= 1'b1;
    do @(posedge clk); while (busy);
    conv_model.note_transaction(in_item);
  endtask

  task drain;
    pause(1);
    while (conv_model.expected_results.size() != 0 || busy) @(posedge clk);
  endtask

  function int small_value();
    return $urandom_range(0, 1023) - 512;
  endfunction

  // mode 0: constant value, mode 1: small random values
  task fill(op_t op, int depth, int mode, int val);
    for (int a = 0; a < depth; a++) send(op, a, mode ? small_value() : val);
  endtask

  initial begin
    int r;
    conv_model = new();
    cycles = 0;
    allow_gaps = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // saturate high: negative times negative everywhere
    fill(OP_LOAD_F, F_DEPTH, 0, -32768);
    fill(OP_LOAD_W, W_DEPTH, 0, -32768);
    fill(OP_LOAD_B, B_DEPTH, 0, 32767);
    send(OP_COMPUTE, 0, 0);
    // out-of-range loads must leave the memories alone
    send(OP_LOAD_W, W_DEPTH, 0);
    send(OP_LOAD_W, 4095, 0);
    send(OP_LOAD_B, B_DEPTH, 0);
    send(OP_LOAD_B, 4095, 0);
    send(OP_LOAD_F, F_DEPTH, 0);
    send(OP_LOAD_F, 4095, 0);
    send(OP_COMPUTE, NPOS - 1, -1);
    // saturate low
    fill(OP_LOAD_W, W_DEPTH, 0, 32767);
    fill(OP_LOAD_B, B_DEPTH, 0, -32768);
    send(OP_COMPUTE, NPOS / 2, 0);
    send(OP_COMPUTE, NPOS, 0);
    send(OP_COMPUTE, 4095, 32767);
    drain();

    allow_gaps = 1;
    fill(OP_LOAD_F, F_DEPTH, 1, 0);
    fill(OP_LOAD_W, W_DEPTH, 1, 0);
    fill(OP_LOAD_B, B_DEPTH, 1, 0);
    send(OP_COMPUTE, 0, 0);
    send(OP_COMPUTE, OW - 1, 0);

    for (int i = 0; i < 130; i++) begin
      if (i == 60) drain();
      if (i >= 105) allow_gaps = 0;
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send(OP_COMPUTE, $urandom_range(0, NPOS - 1), $urandom);
      end else if (r < 45) begin
        send(OP_COMPUTE, $urandom_range(NPOS, 4095), $urandom);
      end else if (r < 90) begin
        case ($urandom_range(0, 2))
          0: send(OP_LOAD_W, $urandom_range(0, W_DEPTH - 1),
                  ($urandom_range(0, 9) == 0) ? $urandom : small_value());
          1: send(OP_LOAD_B, $urandom_range(0, B_DEPTH - 1),
                  ($urandom_range(0, 9) == 0) ? $urandom : small_value());
          default: send(OP_LOAD_F, $urandom_range(0, F_DEPTH - 1),
                        ($urandom_range(0, 9) == 0) ? $urandom : small_value());
        endcase
      end else begin
        send(op_t'($urandom_range(0, 2)), $urandom_range(F_DEPTH, 4095), $urandom);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (conv_model.errors == 0 && conv_model.expected_results.size() == 0) begin
      $display("[conv_multichannel_5x5_layer] OK");
    end else begin
      $display("[conv_multichannel_5x5_layer] ERROR");
    end
    $finish;
  end
endmodule
